>>> design/byte_stuffing_framer_defines.svh
// Assertion macros shared by the byte stuffing framer modules
`ifndef BYTE_STUFFING_FRAMER_DEFINES_SVH
`define BYTE_STUFFING_FRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bsf_pkg.sv
// Shared types and constants for the byte stuffing framer
`timescale 1ns / 1ps

package bsf_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_IDX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_IDX  = 1'd1;

  localparam logic [BYTE_W-1:0] FLAG_RESET = 8'd36;
  localparam logic [BYTE_W-1:0] ESC_RESET  = 8'd47;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              open;
    logic              esc;
    logic              last;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] flag;
    logic [BYTE_W-1:0] escape;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef enum logic [2:0] {
    S_OPEN,
    S_ESC,
    S_DATA,
    S_CLOSE,
    S_TRAIL
  } step_t;

endpackage

>>> design/bsf_front.sv
// Front end: takes message bytes, holds config and frame state, classifies each byte
`timescale 1ns / 1ps

module bsf_front import bsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_last_byte,
  input  logic                 q_full,
  output q_wr_t                q_wr,
  output cmd_t                 q_cmd
);

  logic [BYTE_W-1:0] flag_byte_r, flag_byte_nxt;
  logic [BYTE_W-1:0] escape_byte_r, escape_byte_nxt;
  logic              inside_r, inside_nxt;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    flag_byte_nxt   = flag_byte_r;
    escape_byte_nxt = escape_byte_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLAG_IDX: flag_byte_nxt   = cfg_data;
        CFG_ESC_IDX:  escape_byte_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    inside_nxt = inside_r;
    if (accept) begin
      inside_nxt = !in_last_byte;
    end
  end

  always_comb begin
    q_cmd.open   = !inside_r;
    q_cmd.esc    = (in_data_byte == flag_byte_r) || (in_data_byte == escape_byte_r);
    q_cmd.last   = in_last_byte;
    q_cmd.data   = in_data_byte;
    q_cmd.flag   = flag_byte_r;
    q_cmd.escape = escape_byte_r;
    q_wr.push    = accept;
    q_wr.full    = q_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_byte_r   <= FLAG_RESET;
      escape_byte_r <= ESC_RESET;
      inside_r      <= 1'b0;
    end else begin
      flag_byte_r   <= flag_byte_nxt;
      escape_byte_r <= escape_byte_nxt;
      inside_r      <= inside_nxt;
    end
  end

endmodule

>>> design/bsf_queue.sv
// Short request queue between the front end and the byte sequencer
`timescale 1ns / 1ps

`include "byte_stuffing_framer_defines.svh"

module bsf_queue import bsf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  input  cmd_t  q_cmd,
  output logic  q_full,
  input  logic  q_pop,
  output logic  q_valid,
  output cmd_t  q_head
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_full  = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = q_wr.push && !q_wr.full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_cmd;
    end
  end

  `BSF_ASSERT_NOW(a_no_push_when_full, q_full, !q_wr.push, "request pushed into full queue")
  `BSF_ASSERT_NOW(a_count_bound, 1'b1, count_r <= QCNT_W'(QDEPTH), "queue count overflow")
  `BSF_ASSERT_NEXT(a_count_track, do_push && !do_pop, count_r == $past(count_r) + 1'b1,
                   "queue count lost a push")

endmodule

>>> design/bsf_back.sv
// Back end: walks each request through the flag, escape, data, close and trailer bytes it needs
`timescale 1ns / 1ps

`include "byte_stuffing_framer_defines.svh"

module bsf_back import bsf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cmd_t              q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_is_trailer,
  output logic              out_frame_done
);

  step_t             step_r, step_nxt;
  step_t             cur_step, next_step;
  logic              mid_r, mid_nxt;
  logic [BYTE_W-1:0] parity_r, parity_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_trl_r;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit, done, is_trl;

  assign emit = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (mid_r) begin
      cur_step = step_r;
    end else if (q_head.open) begin
      cur_step = S_OPEN;
    end else if (q_head.esc) begin
      cur_step = S_ESC;
    end else begin
      cur_step = S_DATA;
    end
  end

  always_comb begin
    emit_byte = q_head.data;
    next_step = S_DATA;
    done      = 1'b0;
    is_trl    = 1'b0;
    unique case (cur_step)
      S_OPEN: begin
        emit_byte = q_head.flag;
        next_step = q_head.esc ? S_ESC : S_DATA;
      end
      S_ESC: begin
        emit_byte = q_head.escape;
        next_step = S_DATA;
      end
      S_DATA: begin
        emit_byte = q_head.data;
        next_step = S_CLOSE;
        done      = !q_head.last;
      end
      S_CLOSE: begin
        emit_byte = q_head.flag;
        next_step = S_TRAIL;
      end
      S_TRAIL: begin
        emit_byte = parity_r;
        next_step = S_OPEN;
        done      = 1'b1;
        is_trl    = 1'b1;
      end
      default: begin
        emit_byte = q_head.data;
        done      = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_nxt   = step_r;
    mid_nxt    = mid_r;
    parity_nxt = parity_r;
    if (emit) begin
      step_nxt = next_step;
      mid_nxt  = !done;
      if (is_trl) begin
        parity_nxt = '0;
      end else if (cur_step == S_OPEN) begin
        parity_nxt = emit_byte;
      end else begin
        parity_nxt = parity_r ^ emit_byte;
      end
    end
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  assign q_pop = emit && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_OPEN;
      mid_r       <= 1'b0;
      parity_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      mid_r       <= mid_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_trl_r  <= is_trl;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_is_trailer = out_trl_r;
  assign out_frame_done = out_trl_r;

  `BSF_ASSERT_NOW(a_mid_has_head, mid_r, q_valid, "sequencer mid-request with empty queue")
  `BSF_ASSERT_NEXT(a_trail_clears, emit && is_trl, parity_r == '0 && !mid_r,
                   "trailer did not close the frame")
  `BSF_ASSERT_NEXT(a_open_seeds, emit && cur_step == S_OPEN, parity_r == out_byte_r,
                   "opening flag did not seed parity")

endmodule

>>> design/byte_stuffing_framer.sv
// Byte stuffing framer with XOR parity trailer, top level
// A request's first result byte passes through the request queue and the output register.
// The sequencer gives one result byte per cycle while a request is queued and out_stall is low;
// a request yields its data byte, plus the open flag, escape, close flag and trailer as needed.
// A four-entry request queue lets the input side run ahead of the sequencer.
// Reset clears the frame state, queue and output valid, and loads flag 36 and escape 47.
`timescale 1ns / 1ps

module byte_stuffing_framer import bsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_is_trailer,
  output logic                 out_frame_done
);

  q_wr_t q_wr;
  cmd_t  q_cmd;
  cmd_t  q_head;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  bsf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_cmd        (q_cmd)
  );

  bsf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_cmd   (q_cmd),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  bsf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_trailer (out_is_trailer),
    .out_frame_done (out_frame_done)
  );

endmodule
